/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the binary-lifting tree unit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while in reset
`define BL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("binary lifting unit: implication check failed");

// Next-cycle implication, ignored while in reset
`define BL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("binary lifting unit: next-cycle check failed");

`endif

/* hw/rtl/bllme_pkg.sv */
// Package for the binary-lifting tree unit: widths, codes, table entry type.
// No dependencies; used by binary_lifting_lca_max_edge_unit.
package bllme_pkg;

  localparam int NODE_W     = 10;
  localparam int WEIGHT_W   = 31;
  localparam int LVL_W      = 4;
  localparam int LEVELS     = 11;
  localparam int NODE_COUNT = 2 ** NODE_W;
  localparam int TBL_DEPTH  = 2 ** (NODE_W + LVL_W);

  localparam logic [LVL_W-1:0]  TOP_LVL  = LVL_W'(LEVELS - 1);
  localparam logic [NODE_W-1:0] NODE_MAX = {NODE_W{1'b1}};

  typedef logic [NODE_W-1:0]        node_t;
  typedef logic [WEIGHT_W-1:0]      weight_t;
  typedef logic [LVL_W-1:0]         lvl_t;
  typedef logic [NODE_W+LVL_W-1:0]  tbl_addr_t;

  // One row of the lifting table: 2^j-th ancestor and the largest weight on that jump
  typedef struct packed {
    node_t   anc;
    weight_t jmax;
  } entry_t;

  typedef enum logic [1:0] {
    FN_INS = 2'd0,
    FN_LCA = 2'd1,
    FN_KTH = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_INS0,
    ST_INSL,
    ST_DEP,
    ST_SET,
    ST_CLB,
    ST_CMP,
    ST_CEND,
    ST_FIN
  } state_e;

  function automatic weight_t wmax(weight_t x, weight_t y);
    return (x > y) ? x : y;
  endfunction

endpackage

/* hw/rtl/binary_lifting_lca_max_edge_unit.sv */
// Binary-lifting tree unit: sequencer, lifting table and depth memories.
// Depends on bllme_pkg and assert_macros.svh.
//
// Usage: the host sends one item per transfer on the input channel (valid/ready).
// func 0 inserts node_a under parent node_b with edge weight; a node that is
// its own parent is a root. Parents must be inserted before their children.
// func 1 returns the lowest common ancestor of node_a and node_b, func 2 the
// ancestor of node_a that lies steps levels up (stopping at the root). Both
// queries also return the largest edge weight on the path walked.
// Every item gives exactly one result on the output channel.
// One table level is visited per cycle, over the 11 levels of the table.
// The input is ready only in idle; the next item is taken the cycle after
// the result is loaded into the output register, so a stalled receiver
// holds back at most one finished result. Reset clears the sequencer and
// the output valid only; the tables keep their contents and read as
// undefined until an insert writes them.
module binary_lifting_lca_max_edge_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             func_i,
  input  bllme_pkg::node_t       node_a_i,
  input  bllme_pkg::node_t       node_b_i,
  input  bllme_pkg::weight_t     weight_i,
  input  bllme_pkg::node_t       steps_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output bllme_pkg::node_t       node_o,
  output bllme_pkg::weight_t     path_max_o
);
  import bllme_pkg::*;

  state_e  state_q, state_d;
  func_e   func_q, func_d;
  lvl_t    lvl_q, lvl_d;
  node_t   x_q, x_d;
  node_t   y_q, y_d;
  node_t   steps_q, steps_d;
  weight_t max_q, max_d;
  logic [LEVELS-1:0] k_q, k_d;

  logic    out_valid_q, out_valid_d;
  node_t   out_node_q, out_node_d;
  weight_t out_max_q, out_max_d;

  // Lifting table: one write port, two read ports with write-first bypass
  entry_t    tbl_mem [TBL_DEPTH];
  entry_t    ra_q, rb_q;
  logic      tbl_we;
  tbl_addr_t tbl_waddr, tbl_ra_addr, tbl_rb_addr;
  entry_t    tbl_wdata;

  // Depth memory: one write port, two read ports
  node_t     dep_mem [NODE_COUNT];
  node_t     da_q, db_q;
  logic      dep_re, dep_we;
  node_t     dep_ra_addr, dep_rb_addr, dep_waddr, dep_wdata;

  weight_t   step_max, pair_max;
  node_t     dep_inc;
  node_t     k_val;

  logic      out_stall, tbl_write_state;

  assign step_max = wmax(max_q, ra_q.jmax);
  assign pair_max = wmax(max_q, wmax(ra_q.jmax, rb_q.jmax));
  assign dep_inc  = (da_q == NODE_MAX) ? NODE_MAX : da_q + NODE_W'(1);

  // Table memory
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    ra_q <= (tbl_we && tbl_waddr == tbl_ra_addr) ? tbl_wdata : tbl_mem[tbl_ra_addr];
    rb_q <= (tbl_we && tbl_waddr == tbl_rb_addr) ? tbl_wdata : tbl_mem[tbl_rb_addr];
  end

  // Depth memory
  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    if (dep_re) begin
      da_q <= dep_mem[dep_ra_addr];
      db_q <= dep_mem[dep_rb_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      func_q      <= FN_INS;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    steps_q    <= steps_d;
    max_q      <= max_d;
    k_q        <= k_d;
    out_node_q <= out_node_d;
    out_max_q  <= out_max_d;
  end

  // Sequencer: next state, datapath updates, memory control
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    lvl_d       = lvl_q;
    x_d         = x_q;
    y_d         = y_q;
    steps_d     = steps_q;
    max_d       = max_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_node_d  = out_node_q;
    out_max_d   = out_max_q;
    tbl_we      = 1'b0;
    tbl_waddr   = {x_q, lvl_q};
    tbl_wdata   = '0;
    tbl_ra_addr = {x_q, lvl_q};
    tbl_rb_addr = {y_q, lvl_q};
    dep_re      = 1'b0;
    dep_we      = 1'b0;
    dep_ra_addr = x_q;
    dep_rb_addr = y_q;
    dep_waddr   = x_q;
    dep_wdata   = '0;
    k_val       = '0;

    // Drop the result once the receiver takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_e'(func_i);
          x_d     = node_a_i;
          y_d     = node_b_i;
          steps_d = steps_i;
          lvl_d   = '0;
          max_d   = '0;
          case (func_e'(func_i))
            FN_INS: begin
              max_d   = weight_i;
              state_d = (node_a_i == node_b_i) ? ST_ROOT : ST_INS0;
            end
            FN_LCA, FN_KTH: begin
              state_d = ST_DEP;
            end
            default: begin
              x_d     = '0;
              state_d = ST_FIN;
            end
          endcase
        end
      end

      // Root: own ancestor at every level, zero jump weights, depth 0
      ST_ROOT: begin
        tbl_we    = 1'b1;
        tbl_wdata = '{anc: x_q, jmax: '0};
        if (lvl_q == '0) begin
          dep_we = 1'b1;
        end
        if (lvl_q == TOP_LVL) begin
          max_d   = '0;
          state_d = ST_FIN;
        end else begin
          lvl_d = lvl_q + LVL_W'(1);
        end
      end

      // Level 0 of an insert; fetch the parent's level-0 row and depth
      ST_INS0: begin
        tbl_we      = 1'b1;
        tbl_wdata   = '{anc: y_q, jmax: max_q};
        tbl_ra_addr = {y_q, lvl_t'(0)};
        dep_re      = 1'b1;
        dep_ra_addr = y_q;
        lvl_d       = LVL_W'(1);
        state_d     = ST_INSL;
      end

      // Level L of an insert: chain through the midpoint's level L-1 row
      ST_INSL: begin
        tbl_we    = 1'b1;
        tbl_wdata = '{anc: ra_q.anc, jmax: step_max};
        max_d     = step_max;
        if (lvl_q == TOP_LVL) begin
          dep_we    = 1'b1;
          dep_wdata = dep_inc;
          max_d     = '0;
          state_d   = ST_FIN;
        end else begin
          tbl_ra_addr = {ra_q.anc, lvl_q};
          lvl_d       = lvl_q + LVL_W'(1);
        end
      end

      ST_DEP: begin
        dep_re  = 1'b1;
        state_d = ST_SET;
      end

      // Order the pair by depth or clamp the step count, then start the climb
      ST_SET: begin
        if (func_q == FN_LCA) begin
          if (da_q < db_q) begin
            x_d   = y_q;
            y_d   = x_q;
            k_val = db_q - da_q;
          end else begin
            k_val = da_q - db_q;
          end
        end else begin
          k_val = (steps_q > da_q) ? da_q : steps_q;
        end
        k_d         = {1'b0, k_val};
        lvl_d       = TOP_LVL;
        tbl_ra_addr = {x_d, TOP_LVL};
        state_d     = ST_CLB;
      end

      // Climb: take the jump at this level if its step bit is set
      ST_CLB: begin
        if (k_q[LEVELS-1]) begin
          x_d   = ra_q.anc;
          max_d = step_max;
        end
        k_d = {k_q[LEVELS-2:0], 1'b0};
        if (lvl_q == '0) begin
          if (func_q == FN_LCA) begin
            tbl_ra_addr = {x_d, TOP_LVL};
            tbl_rb_addr = {y_q, TOP_LVL};
            lvl_d       = TOP_LVL;
            state_d     = ST_CMP;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          tbl_ra_addr = {x_d, lvl_q - LVL_W'(1)};
          lvl_d       = lvl_q - LVL_W'(1);
        end
      end

      // Lift both nodes together while their ancestors differ
      ST_CMP: begin
        if (ra_q.anc != rb_q.anc) begin
          x_d   = ra_q.anc;
          y_d   = rb_q.anc;
          max_d = pair_max;
        end
        if (lvl_q == '0) begin
          tbl_ra_addr = {x_d, lvl_t'(0)};
          tbl_rb_addr = {y_d, lvl_t'(0)};
          state_d     = ST_CEND;
        end else begin
          tbl_ra_addr = {x_d, lvl_q - LVL_W'(1)};
          tbl_rb_addr = {y_d, lvl_q - LVL_W'(1)};
          lvl_d       = lvl_q - LVL_W'(1);
        end
      end

      // Final step to the common parent unless the nodes already met
      ST_CEND: begin
        if (x_q != y_q) begin
          x_d   = ra_q.anc;
          max_d = pair_max;
        end
        state_d = ST_FIN;
      end

      // Load the output register once it is free
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_node_d  = x_q;
          out_max_d   = max_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign node_o      = out_node_q;
  assign path_max_o  = out_max_q;

  // Condition terms for the checks below
  assign out_stall       = out_valid_q && !out_ready_i;
  assign tbl_write_state = (state_q == ST_ROOT) || (state_q == ST_INS0) || (state_q == ST_INSL);

  `include "assert_macros.svh"

  `BL_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != ST_IDLE)
  `BL_ASSERT_NEXT(a_fin_holds_on_stall, state_q == ST_FIN && out_stall, state_q == ST_FIN)
  `BL_ASSERT_IMP(a_lvl_in_range, 1'b1, lvl_q <= TOP_LVL)
  `BL_ASSERT_IMP(a_single_writer_step, tbl_we, tbl_write_state)

endmodule

/* sim/binary_lifting_lca_max_edge_unit_tb.sv */
// Self-checking testbench for binary_lifting_lca_max_edge_unit: directed table, random trees,
// a long ping-pong chain, random idles on both channels and a long output stall.
// Depends on bllme_pkg and the unit RTL only.
module binary_lifting_lca_max_edge_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bllme_pkg::*;

  localparam logic [1:0] FN_UNUSED  = 2'd3;
  localparam int         RAND_ITEMS = 300;
  localparam int         CHAIN_LEN  = 70;
  localparam int         IDLE_PCT   = 27;
  localparam int         HOLD_AT    = 60;
  localparam int         HOLD_CYC   = 300;
  localparam int         DRAIN_CYC  = 40;
  localparam int         WDOG_LIMIT = 2000;
  localparam int         DIR_N      = 23;
  localparam weight_t    W_MAX      = {WEIGHT_W{1'b1}};

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] func_i;
  node_t      node_a_i;
  node_t      node_b_i;
  weight_t    weight_i;
  node_t      steps_i;
  logic       out_valid_o;
  logic       out_ready_i;
  node_t      node_o;
  weight_t    path_max_o;

  binary_lifting_lca_max_edge_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .weight_i    (weight_i),
    .steps_i     (steps_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .node_o      (node_o),
    .path_max_o  (path_max_o)
  );

  typedef struct packed {
    node_t   node;
    weight_t pmax;
  } tree_answer_t;

  // One directed row; typed rows carry their answer, the rest go to the predictor
  typedef struct packed {
    logic [1:0] f;
    node_t      a;
    node_t      b;
    weight_t    w;
    node_t      k;
    bit         typed;
    node_t      en;
    weight_t    ep;
  } dir_row_t;

  dir_row_t dir_rows [DIR_N] = '{
    '{FN_INS,    10'd0,    10'd0,    31'd0,          10'd0,    1'b1, 10'd0,    31'd0},
    '{FN_INS,    10'd1023, 10'd0,    31'h7FFF_FFFF,  10'd0,    1'b1, 10'd1023, 31'd0},
    '{FN_INS,    10'd5,    10'd1023, 31'd0,          10'd0,    1'b1, 10'd5,    31'd0},
    '{FN_INS,    10'd6,    10'd1023, 31'd7,          10'd0,    1'b1, 10'd6,    31'd0},
    '{FN_INS,    10'd512,  10'd512,  31'h7FFF_FFFF,  10'd0,    1'b1, 10'd512,  31'd0},
    '{FN_INS,    10'd513,  10'd512,  31'd3,          10'd0,    1'b1, 10'd513,  31'd0},
    '{FN_LCA,    10'd5,    10'd6,    31'd0,          10'd0,    1'b0, 10'd0,    31'd0},
    '{FN_KTH,    10'd5,    10'd0,    31'd0,          10'd1023, 1'b0, 10'd0,    31'd0},
    '{FN_KTH,    10'd5,    10'd0,    31'd0,          10'd0,    1'b0, 10'd0,    31'd0},
    '{FN_LCA,    10'd5,    10'd5,    31'd0,          10'd0,    1'b0, 10'd0,    31'd0},
    '{FN_LCA,    10'd513,  10'd6,    31'd0,          10'd0,    1'b0, 10'd0,    31'd0},
    '{FN_LCA,    10'd0,    10'd512,  31'd0,          10'd0,    1'b0, 10'd0,    31'd0},
    '{FN_UNUSED, 10'd1023, 10'd1023, 31'h7FFF_FFFF,  10'd1023, 1'b1, 10'd0,    31'd0},
    '{FN_INS,    10'd6,    10'd513,  31'd9,          10'd0,    1'b1, 10'd6,    31'd0},
    '{FN_KTH,    10'd6,    10'd0,    31'd0,          10'd2,    1'b0, 10'd0,    31'd0},
    '{FN_LCA,    10'd6,    10'd5,    31'd0,          10'd0,    1'b0, 10'd0,    31'd0},
    '{FN_INS,    10'd1,    10'd0,    31'h5555_5555,  10'd0,    1'b1, 10'd1,    31'd0},
    '{FN_INS,    10'd2,    10'd1,    31'h2AAA_AAAA,  10'd0,    1'b1, 10'd2,    31'd0},
    '{FN_LCA,    10'd2,    10'd1023, 31'd0,          10'd0,    1'b0, 10'd0,    31'd0},
    '{FN_KTH,    10'd2,    10'd0,    31'd0,          10'd1,    1'b0, 10'd0,    31'd0},
    '{FN_KTH,    10'd1023, 10'd0,    31'd0,          10'd1,    1'b0, 10'd0,    31'd0},
    '{FN_INS,    10'd3,    10'd2,    31'd0,          10'd0,    1'b1, 10'd3,    31'd0},
    '{FN_LCA,    10'd3,    10'd5,    31'd0,          10'd0,    1'b0, 10'd0,    31'd0}
  };

  // Mirror of the lifting tables
  node_t   anc_tab [NODE_COUNT][LEVELS];
  weight_t jmx_tab [NODE_COUNT][LEVELS];
  node_t   dep_tab [NODE_COUNT];
  bit      present [NODE_COUNT];
  node_t   known_nodes [$];

  tree_answer_t tree_answer_q [$];

  int  err_cnt;
  int  answers_seen;
  int  n_ins, n_lca, n_kth, n_other;
  int  idle_cnt;
  bit  no_gaps;
  bit  hold_done;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic weight_t heavier(weight_t x, weight_t y);
    return (x > y) ? x : y;
  endfunction

  // Climb k levels, clamped to the depth and to the table reach
  function automatic node_t climb_up(node_t start, int unsigned k, inout weight_t pm);
    node_t x = start;
    if (k > dep_tab[x]) k = dep_tab[x];
    if (k > (2 ** LEVELS) - 1) k = (2 ** LEVELS) - 1;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if ((k >> lv) & 1) begin
        pm = heavier(pm, jmx_tab[x][lv]);
        x  = anc_tab[x][lv];
      end
    end
    return x;
  endfunction

  function automatic void insert_lift(node_t n, node_t par, weight_t w);
    int unsigned d;
    node_t       mid;
    if (par == n) begin
      for (int lv = 0; lv < LEVELS; lv++) begin
        anc_tab[n][lv] = n;
        jmx_tab[n][lv] = '0;
      end
      dep_tab[n] = '0;
      return;
    end
    d = dep_tab[par] + 1;
    anc_tab[n][0] = par;
    jmx_tab[n][0] = w;
    for (int lv = 1; lv < LEVELS; lv++) begin
      mid = anc_tab[n][lv-1];
      anc_tab[n][lv] = anc_tab[mid][lv-1];
      jmx_tab[n][lv] = heavier(jmx_tab[n][lv-1], jmx_tab[mid][lv-1]);
    end
    if (d > NODE_COUNT - 1) d = NODE_COUNT - 1;
    dep_tab[n] = node_t'(d);
  endfunction

  function automatic node_t common_lift(node_t a, node_t b, inout weight_t pm);
    node_t t;
    if (dep_tab[a] < dep_tab[b]) begin
      t = a;
      a = b;
      b = t;
    end
    a = climb_up(a, dep_tab[a] - dep_tab[b], pm);
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (anc_tab[a][lv] != anc_tab[b][lv]) begin
        pm = heavier(pm, heavier(jmx_tab[a][lv], jmx_tab[b][lv]));
        a  = anc_tab[a][lv];
        b  = anc_tab[b][lv];
      end
    end
    if (a == b) return a;
    pm = heavier(pm, heavier(jmx_tab[a][0], jmx_tab[b][0]));
    return anc_tab[a][0];
  endfunction

  function automatic tree_answer_t tree_predict(logic [1:0] f, node_t a, node_t b, weight_t w,
                                                node_t k);
    tree_answer_t ans;
    weight_t      pm = '0;
    ans = '0;
    case (f)
      FN_INS: begin
        insert_lift(a, b, w);
        ans.node = a;
      end
      FN_LCA: ans.node = common_lift(a, b, pm);
      FN_KTH: ans.node = climb_up(a, k, pm);
      default: ans.node = '0;
    endcase
    ans.pmax = pm;
    return ans;
  endfunction

  // After optional random idles, offer one item, hold it until the transfer, then record its answer
  task automatic offer(logic [1:0] f, node_t a, node_t b, weight_t w, node_t k,
                       bit typed, node_t en, weight_t ep);
    tree_answer_t ans;
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    node_a_i   <= a;
    node_b_i   <= b;
    weight_i   <= w;
    steps_i    <= k;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ans = tree_predict(f, a, b, w, k);
    if (typed) begin
      ans.node = en;
      ans.pmax = ep;
    end
    tree_answer_q.push_back(ans);
    case (f)
      FN_INS: begin
        n_ins++;
        if (!present[a]) begin
          present[a] = 1'b1;
          known_nodes.push_back(a);
        end
      end
      FN_LCA: n_lca++;
      FN_KTH: n_kth++;
      default: n_other++;
    endcase
    @(negedge clk_i);
  endtask

  function automatic node_t pick_known();
    return known_nodes[$urandom_range(known_nodes.size() - 1)];
  endfunction

  function automatic weight_t pick_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return W_MAX;
      default: return weight_t'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = FN_INS;
    node_a_i    = '0;
    node_b_i    = '0;
    weight_i    = '0;
    steps_i     = '0;
    no_gaps     = 1'b0;
    err_cnt     = 0;
    n_ins       = 0;
    n_lca       = 0;
    n_kth       = 0;
    n_other     = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows
    for (int i = 0; i < DIR_N; i++) begin
      offer(dir_rows[i].f, dir_rows[i].a, dir_rows[i].b, dir_rows[i].w, dir_rows[i].k,
            dir_rows[i].typed, dir_rows[i].en, dir_rows[i].ep);
    end

    // Random trees: mostly well-formed inserts and queries, a few unused codes
    for (int i = 0; i < RAND_ITEMS; i++) begin
      int      r;
      node_t   a;
      node_t   b;
      node_t   k;
      no_gaps = (i >= 150 && i < 250);
      r = $urandom_range(99);
      if (r < 35) begin
        a = node_t'($urandom);
        b = ($urandom_range(9) == 0) ? a : pick_known();
        offer(FN_INS, a, b, pick_weight(), node_t'($urandom), 1'b0, '0, '0);
      end else if (r < 65) begin
        offer(FN_LCA, pick_known(), pick_known(), pick_weight(), node_t'($urandom),
              1'b0, '0, '0);
      end else if (r < 95) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: k = node_t'($urandom_range(15));
          5:             k = NODE_MAX;
          default:       k = node_t'($urandom);
        endcase
        offer(FN_KTH, pick_known(), pick_known(), pick_weight(), k, 1'b0, '0, '0);
      end else begin
        offer(FN_UNUSED, pick_known(), pick_known(), pick_weight(), node_t'($urandom),
              1'b1, '0, '0);
      end
    end
    no_gaps = 1'b0;

    // Ping-pong two nodes under each other to build a deep chain
    offer(FN_INS, 10'd1021, 10'd1021, pick_weight(), '0, 1'b0, '0, '0);
    for (int i = 0; i < CHAIN_LEN; i++) begin
      if (i % 2 == 0) offer(FN_INS, 10'd1022, 10'd1021, pick_weight(), '0, 1'b0, '0, '0);
      else            offer(FN_INS, 10'd1021, 10'd1022, pick_weight(), '0, 1'b0, '0, '0);
    end
    offer(FN_KTH, 10'd1021, 10'd0, '0, NODE_MAX, 1'b0, '0, '0);
    offer(FN_KTH, 10'd1022, 10'd0, '0, NODE_MAX, 1'b0, '0, '0);
    offer(FN_KTH, 10'd1022, 10'd0, '0, 10'd700, 1'b0, '0, '0);
    offer(FN_LCA, 10'd1021, 10'd1022, '0, '0, 1'b0, '0, '0);
    offer(FN_LCA, 10'd1022, pick_known(), '0, '0, 1'b0, '0, '0);
    offer(FN_LCA, pick_known(), 10'd1021, '0, '0, 1'b0, '0, '0);
    in_valid_i <= 1'b0;

    // Drain
    while (tree_answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Sent %0d inserts, %0d common-ancestor and %0d k-th queries, %0d unused codes;",
             n_ins, n_lca, n_kth, n_other);
    $display("checked %0d answers, incl. a %0d-deep chain and a %0d-cycle output stall.",
             answers_seen, CHAIN_LEN, HOLD_CYC);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off
  initial begin
    out_ready_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && answers_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
      end
      out_ready_i <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each result transfer with the oldest answer
  always @(posedge clk_i) begin
    tree_answer_t exp_ans;
    if (rst_ni && out_valid_o && out_ready_i) begin
      answers_seen++;
      if (tree_answer_q.size() == 0) begin
        err_cnt++;
        $error("unexpected result: node %0d path_max %0d", node_o, path_max_o);
      end else begin
        exp_ans = tree_answer_q.pop_front();
        if (node_o !== exp_ans.node) begin
          err_cnt++;
          $error("node: expected %0d, actual %0d", exp_ans.node, node_o);
        end
        if (path_max_o !== exp_ans.pmax) begin
          err_cnt++;
          $error("path_max: expected %0d, actual %0d", exp_ans.pmax, path_max_o);
        end
      end
    end
  end

  // Watchdog: abort when no transfer happens for too long
  initial begin
    idle_cnt     = 0;
    answers_seen = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= WDOG_LIMIT) begin
          $display("timeout after %0d cycles without a transfer", WDOG_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

endmodule
